[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the tile name table expander, checked on clk, rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TRE_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tre: forbidden condition seen");
`define TRE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tre: implication failed");
`else
`define TRE_ASSERT_NEVER(lbl, cond)
`define TRE_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

[rtl/tre_pkg.sv]
// ----------------------------------------------------------------------------
// tre_pkg
// shared types and constants of the tile name table expander
// ----------------------------------------------------------------------------
package tre_pkg;

    localparam int WORD_W  = 16;
    localparam int BASE_W  = 24;
    localparam int ROWS_W  = 8;
    localparam int PAGE_W  = 3;
    localparam int CIDX_W  = 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [BASE_W-1:0] BASE_RESET  = 24'h100F80;
    localparam logic [ROWS_W-1:0] ROWS_RESET  = 8'd32;
    localparam logic [PAGE_W-1:0] PAGES_RESET = 3'd4;

    localparam int ROW_BACK   = 'h100;
    localparam int PAGE_SHIFT = 12;

    localparam logic [CIDX_W-1:0] CFG_DST_BASE      = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ROWS_PER_PAGE = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_PAGE_COUNT    = 2'd2;

    typedef enum logic [1:0] {
        PH_TOKEN = 2'd0,
        PH_VALUE = 2'd1,
        PH_COUNT = 2'd2
    } phase_t;

    typedef enum logic {
        KIND_DATA  = 1'b0,
        KIND_START = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [WORD_W-1:0] data;
        logic [WORD_W-1:0] count;
    } qent_t;

    typedef struct packed {
        logic  valid;
        qent_t ent;
    } qslot_t;

    typedef struct packed {
        logic [BASE_W-1:0] dst_base;
        logic [ROWS_W-1:0] rows_per_page;
        logic [PAGE_W-1:0] page_count;
    } cfg_t;

endpackage

[rtl/tre_front.sv]
// ----------------------------------------------------------------------------
// tre_front
// takes stream words, tracks token/value/count phase, queues write jobs and start commands
// ----------------------------------------------------------------------------
module tre_front
    import tre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              word_valid,
    output logic              word_stall,
    input  logic              cmd,
    input  logic [WORD_W-1:0] word,
    input  logic              q_full,
    output qslot_t            q_push
);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [WORD_W-1:0] run_value_reg;
    logic [WORD_W-1:0] run_value_next;
    logic              accept;

    assign word_stall = q_full;
    assign accept     = word_valid && !q_full;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (cmd)
            begin
                phase_next = PH_TOKEN;
            end
            else
            begin
                case (phase_reg)
                    PH_TOKEN: phase_next = (word == '0) ? PH_VALUE : PH_TOKEN;
                    PH_VALUE: phase_next = PH_COUNT;
                    PH_COUNT: phase_next = PH_TOKEN;
                    default:  phase_next = PH_TOKEN;
                endcase
            end
        end
    end

    always_comb
    begin
        run_value_next  = run_value_reg;
        q_push.valid    = 1'b0;
        q_push.ent.kind = KIND_DATA;
        q_push.ent.data = word;
        q_push.ent.count = '0;
        if (accept)
        begin
            if (cmd)
            begin
                q_push.valid    = 1'b1;
                q_push.ent.kind = KIND_START;
            end
            else
            begin
                case (phase_reg)
                    PH_TOKEN:
                    begin
                        q_push.valid = (word != '0);
                    end
                    PH_VALUE:
                    begin
                        run_value_next = word;
                    end
                    PH_COUNT:
                    begin
                        q_push.valid     = 1'b1;
                        q_push.ent.data  = run_value_reg;
                        q_push.ent.count = word;
                    end
                    default:
                    begin
                        q_push.valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TOKEN;
            run_value_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            run_value_reg <= run_value_next;
        end
    end

endmodule

[rtl/tre_fifo.sv]
// ----------------------------------------------------------------------------
// tre_fifo
// short job queue between the word parser and the tile writer
// ----------------------------------------------------------------------------
module tre_fifo
    import tre_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  qslot_t q_push,
    output logic   q_full,
    output qslot_t q_head,
    input  logic   q_pop
);

    qent_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign q_full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_head.valid = (count_reg != '0);
    assign q_head.ent   = mem_reg[rd_ptr_reg];

    assign do_push = q_push.valid && !q_full;
    assign do_pop  = q_pop && q_head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_push.ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/tre_back.sv]
// ----------------------------------------------------------------------------
// tre_back
// walks rows and pages, issues one tile write per cycle into the output word while tile_stall is low
// ----------------------------------------------------------------------------
module tre_back
    import tre_pkg::*;
#(
    parameter int ROW_COLUMNS = 64,
    parameter int MAX_PAGES   = 4,
    parameter int ADDR_BITS   = 24
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  qslot_t            q_head,
    output logic              q_pop,
    output logic              tile_valid,
    input  logic              tile_stall,
    output logic [BASE_W-1:0] tile_addr,
    output logic [WORD_W-1:0] tile_data,
    output logic              last_of_item,
    output logic              image_done
);

    localparam int COL_W = $clog2(ROW_COLUMNS + 1);

    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] addr_next;
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     col_next;
    logic [ROWS_W-1:0]    rows_reg;
    logic [ROWS_W-1:0]    rows_next;
    logic [PAGE_W-1:0]    page_reg;
    logic [PAGE_W-1:0]    page_next;
    logic                 finished_reg;
    logic                 finished_next;
    logic                 run_active_reg;
    logic                 run_active_next;
    logic [WORD_W-1:0]    left_reg;
    logic [WORD_W-1:0]    left_next;

    logic                 valid_reg;
    logic                 valid_next;
    logic [BASE_W-1:0]    out_addr_reg;
    logic [BASE_W-1:0]    out_addr_next;
    logic [WORD_W-1:0]    out_data_reg;
    logic [WORD_W-1:0]    out_data_next;
    logic                 out_last_reg;
    logic                 out_last_next;
    logic                 out_done_reg;
    logic                 out_done_next;

    logic                 can_out;
    logic                 is_start;
    logic                 is_data;
    logic                 emit;
    logic [WORD_W-1:0]    left;
    logic                 row_end;
    logic                 last;
    logic                 rows_done;
    logic [PAGE_W:0]      page_inc;
    logic [PAGE_W:0]      eff_pages;
    logic                 final_row;
    logic [ROWS_W-1:0]    eff_rows;

    assign tile_valid   = valid_reg;
    assign tile_addr    = out_addr_reg;
    assign tile_data    = out_data_reg;
    assign last_of_item = out_last_reg;
    assign image_done   = out_done_reg;

    assign can_out  = !valid_reg || !tile_stall;
    assign is_start = q_head.valid && (q_head.ent.kind == KIND_START);
    assign is_data  = q_head.valid && (q_head.ent.kind == KIND_DATA);
    assign emit     = is_data && !finished_reg && can_out;

    assign left      = run_active_reg ? left_reg : q_head.ent.count;
    assign row_end   = (col_reg == COL_W'(1));
    assign last      = (left == '0) || row_end;
    assign rows_done = row_end && (rows_reg <= ROWS_W'(1));
    assign page_inc  = {1'b0, page_reg} + (PAGE_W+1)'(1);
    assign final_row = rows_done && (page_inc >= eff_pages);
    assign eff_rows  = (cfg.rows_per_page == '0) ? ROWS_W'(1) : cfg.rows_per_page;

    always_comb
    begin
        if (cfg.page_count == '0)
        begin
            eff_pages = (PAGE_W+1)'(1);
        end
        else if ({1'b0, cfg.page_count} > (PAGE_W+1)'(MAX_PAGES))
        begin
            eff_pages = (PAGE_W+1)'(MAX_PAGES);
        end
        else
        begin
            eff_pages = {1'b0, cfg.page_count};
        end
    end

    assign q_pop = is_start || (is_data && (finished_reg || (emit && last)));

    // walk state
    always_comb
    begin
        addr_next       = addr_reg;
        col_next        = col_reg;
        rows_next       = rows_reg;
        page_next       = page_reg;
        finished_next   = finished_reg;
        run_active_next = run_active_reg;
        left_next       = left_reg;
        if (is_start)
        begin
            addr_next       = ADDR_BITS'(cfg.dst_base);
            col_next        = COL_W'(ROW_COLUMNS);
            rows_next       = eff_rows;
            page_next       = '0;
            finished_next   = 1'b0;
            run_active_next = 1'b0;
        end
        else if (emit)
        begin
            run_active_next = !last;
            left_next       = left - WORD_W'(1);
            if (!row_end)
            begin
                addr_next = addr_reg + ADDR_BITS'(2);
                col_next  = col_reg - COL_W'(1);
            end
            else
            begin
                col_next = COL_W'(ROW_COLUMNS);
                if (!rows_done)
                begin
                    addr_next = addr_reg + ADDR_BITS'(2) - ADDR_BITS'(ROW_BACK);
                    rows_next = rows_reg - ROWS_W'(1);
                end
                else if (final_row)
                begin
                    addr_next     = addr_reg + ADDR_BITS'(2) - ADDR_BITS'(ROW_BACK);
                    rows_next     = '0;
                    finished_next = 1'b1;
                end
                else
                begin
                    page_next = page_inc[PAGE_W-1:0];
                    rows_next = eff_rows;
                    addr_next = ADDR_BITS'(cfg.dst_base)
                              + (ADDR_BITS'(page_inc[PAGE_W-1:0]) << PAGE_SHIFT);
                end
            end
        end
    end

    // output word
    always_comb
    begin
        valid_next    = can_out ? 1'b0 : valid_reg;
        out_addr_next = out_addr_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        out_done_next = out_done_reg;
        if (emit)
        begin
            valid_next    = 1'b1;
            out_addr_next = BASE_W'(addr_reg);
            out_data_next = q_head.ent.data;
            out_last_next = last;
            out_done_next = final_row;
        end
    end

    always_ff @(posedge clk)
    begin
        out_addr_reg <= out_addr_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
        left_reg     <= left_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= ADDR_BITS'(BASE_RESET);
            col_reg        <= COL_W'(ROW_COLUMNS);
            rows_reg       <= ROWS_RESET;
            page_reg       <= '0;
            finished_reg   <= 1'b0;
            run_active_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            addr_reg       <= addr_next;
            col_reg        <= col_next;
            rows_reg       <= rows_next;
            page_reg       <= page_next;
            finished_reg   <= finished_next;
            run_active_reg <= run_active_next;
            valid_reg      <= valid_next;
        end
    end

endmodule

[rtl/tilemap_rle_expander.sv]
// ----------------------------------------------------------------------------
// tilemap_rle_expander
// zero-escape run-length expander writing a tile name table row by row
// ----------------------------------------------------------------------------
// path: a taken word goes through the queue, and its tile writes leave from the output register
// throughput: one tile write per cycle while tile_stall is low; a run word gives min(count+1, columns
// left in the row) writes, set by the single write stage behind a 4-entry queue
// zero escape and value words give no write and pass at one per cycle while the queue has room
// reset: registers to their defaults and a walk ready at page zero, queue empty
`include "assert_macros.svh"

module tilemap_rle_expander
    import tre_pkg::*;
#(
    parameter int ROW_COLUMNS = 64,
    parameter int MAX_PAGES   = 4,
    parameter int ADDR_BITS   = 24
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [BASE_W-1:0] cfg_wdata,
    input  logic              word_valid,
    output logic              word_stall,
    input  logic              cmd,
    input  logic [WORD_W-1:0] word,
    output logic              tile_valid,
    input  logic              tile_stall,
    output logic [BASE_W-1:0] tile_addr,
    output logic [WORD_W-1:0] tile_data,
    output logic              last_of_item,
    output logic              image_done
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    qslot_t q_push;
    qslot_t q_head;
    logic   q_full;
    logic   q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_DST_BASE:      cfg_next.dst_base      = cfg_wdata;
                CFG_ROWS_PER_PAGE: cfg_next.rows_per_page = cfg_wdata[ROWS_W-1:0];
                CFG_PAGE_COUNT:    cfg_next.page_count    = cfg_wdata[PAGE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dst_base      <= BASE_RESET;
            cfg_reg.rows_per_page <= ROWS_RESET;
            cfg_reg.page_count    <= PAGES_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tre_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .cmd        (cmd),
        .word       (word),
        .q_full     (q_full),
        .q_push     (q_push)
    );

    tre_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .q_head (q_head),
        .q_pop  (q_pop)
    );

    tre_back #(
        .ROW_COLUMNS (ROW_COLUMNS),
        .MAX_PAGES   (MAX_PAGES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .tile_valid   (tile_valid),
        .tile_stall   (tile_stall),
        .tile_addr    (tile_addr),
        .tile_data    (tile_data),
        .last_of_item (last_of_item),
        .image_done   (image_done)
    );

    `TRE_ASSERT_NEVER(a_queue_overflow, q_push.valid && q_full)
    `TRE_ASSERT_IMPL(a_start_drains, q_head.valid && (q_head.ent.kind == KIND_START), q_pop)
    `TRE_ASSERT_IMPL(a_done_is_last, tile_valid && image_done, last_of_item)

endmodule

[verif/tile_write_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_write_checker
// follows the words and register writes taken by the tile name table expander,
// works out the tile writes each word causes and compares them in order with
// the writes the block hands out
// ----------------------------------------------------------------------------
module tile_write_checker
    import tre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [BASE_W-1:0] cfg_wdata,
    input  logic              word_valid,
    input  logic              word_stall,
    input  logic              cmd,
    input  logic [WORD_W-1:0] word,
    input  logic              tile_valid,
    input  logic              tile_stall,
    input  logic [BASE_W-1:0] tile_addr,
    input  logic [WORD_W-1:0] tile_data,
    input  logic              last_of_item,
    input  logic              image_done,
    output int                outstanding,
    output logic              walk_done,
    output int                mismatch_count
);

    localparam int ROW_COLS   = 64;
    localparam int PAGE_LIMIT = 4;

    typedef struct {
        logic [BASE_W-1:0] addr;
        logic [WORD_W-1:0] data;
        logic              last;
        logic              done;
    } tile_write_t;

    tile_write_t       due_writes[$];
    cfg_t              regs;
    phase_t            phase;
    logic [WORD_W-1:0] run_value;
    int                cols_left;
    int                rows_left;
    int                page_idx;
    logic [BASE_W-1:0] next_addr;
    logic              finished;
    int                fails = 0;

    function automatic int rows_eff();
        return (regs.rows_per_page == '0) ? 1 : int'(regs.rows_per_page);
    endfunction

    function automatic int pages_eff();
        if (regs.page_count == '0)
            return 1;
        if (regs.page_count > PAGE_LIMIT)
            return PAGE_LIMIT;
        return int'(regs.page_count);
    endfunction

    function automatic void restart_walk();
        phase     = PH_TOKEN;
        cols_left = ROW_COLS;
        rows_left = rows_eff();
        page_idx  = 0;
        next_addr = regs.dst_base;
        finished  = 1'b0;
    endfunction

    function automatic void write_tile(logic [WORD_W-1:0] data, logic last);
        tile_write_t w;
        w.addr    = next_addr;
        w.data    = data;
        w.last    = last;
        w.done    = 1'b0;
        next_addr = next_addr + BASE_W'(2);
        cols_left--;
        if (cols_left == 0)
        begin
            // row full: step back ROW_BACK from the address past its end
            cols_left = ROW_COLS;
            next_addr = next_addr - BASE_W'(ROW_BACK);
            rows_left--;
            if (rows_left == 0)
            begin
                if (page_idx + 1 >= pages_eff())
                begin
                    finished = 1'b1;
                    phase    = PH_TOKEN;
                    w.done   = 1'b1;
                end
                else
                begin
                    page_idx++;
                    rows_left = rows_eff();
                    next_addr = regs.dst_base + (BASE_W'(page_idx) << PAGE_SHIFT);
                end
            end
        end
        due_writes.push_back(w);
    endfunction

    function automatic void expand_word(logic kind, logic [WORD_W-1:0] w);
        int n;
        if (kind == KIND_START)
        begin
            restart_walk();
            return;
        end
        if (finished)
            return;
        case (phase)
            PH_TOKEN:
            begin
                if (w == '0)
                    phase = PH_VALUE;
                else
                    write_tile(w, 1'b1);
            end
            PH_VALUE:
            begin
                run_value = w;
                phase     = PH_COUNT;
            end
            default:
            begin
                // a run stops at the end of the row
                phase = PH_TOKEN;
                n = (int'(w) + 1 < cols_left) ? int'(w) + 1 : cols_left;
                for (int i = 0; i < n; i++)
                    write_tile(run_value, i == n - 1);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [BASE_W-1:0] want,
                                        logic [BASE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        tile_write_t want;
        if (!rst_n)
        begin
            regs.dst_base      = BASE_RESET;
            regs.rows_per_page = ROWS_RESET;
            regs.page_count    = PAGES_RESET;
            run_value          = '0;
            restart_walk();
            due_writes.delete();
            fails = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_DST_BASE:      regs.dst_base      = cfg_wdata;
                    CFG_ROWS_PER_PAGE: regs.rows_per_page = cfg_wdata[ROWS_W-1:0];
                    CFG_PAGE_COUNT:    regs.page_count    = cfg_wdata[PAGE_W-1:0];
                    default: ;
                endcase
            end
            if (word_valid && !word_stall)
                expand_word(cmd, word);
            if (tile_valid && !tile_stall)
            begin
                if (due_writes.size() == 0)
                begin
                    $error("tile write with none due: addr %h, data %h", tile_addr, tile_data);
                    fails++;
                end
                else
                begin
                    want = due_writes.pop_front();
                    check_field("tile_addr", want.addr, tile_addr);
                    check_field("tile_data", BASE_W'(want.data), BASE_W'(tile_data));
                    check_field("last_of_item", BASE_W'(want.last), BASE_W'(last_of_item));
                    check_field("image_done", BASE_W'(want.done), BASE_W'(image_done));
                end
            end
        end
        outstanding    <= due_writes.size();
        walk_done      <= finished;
        mismatch_count <= fails;
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives the tile name table expander with literal tiles, runs and start
// commands under a series of register settings, with random gaps on the word
// side and random stalls on the tile side; the checker beside the block
// predicts every tile write and counts mismatches
// ----------------------------------------------------------------------------
module tb_top;
    import tre_pkg::*;

    localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int ROW_COLS    = 64;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 42;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              cfg_wr_en  = 1'b0;
    logic [CIDX_W-1:0] cfg_index  = '0;
    logic [BASE_W-1:0] cfg_wdata  = '0;
    logic              word_valid = 1'b0;
    logic              word_stall;
    logic              cmd        = 1'b0;
    logic [WORD_W-1:0] word       = '0;
    logic              tile_valid;
    logic              tile_stall = 1'b0;
    logic [BASE_W-1:0] tile_addr;
    logic [WORD_W-1:0] tile_data;
    logic              last_of_item;
    logic              image_done;
    logic              calm       = 1'b0;
    logic              squeeze_on = 1'b0;
    int                outstanding;
    logic              walk_done;
    int                mismatch_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tilemap_rle_expander u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .word_valid   (word_valid),
        .word_stall   (word_stall),
        .cmd          (cmd),
        .word         (word),
        .tile_valid   (tile_valid),
        .tile_stall   (tile_stall),
        .tile_addr    (tile_addr),
        .tile_data    (tile_data),
        .last_of_item (last_of_item),
        .image_done   (image_done)
    );

    tile_write_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .word_valid     (word_valid),
        .word_stall     (word_stall),
        .cmd            (cmd),
        .word           (word),
        .tile_valid     (tile_valid),
        .tile_stall     (tile_stall),
        .tile_addr      (tile_addr),
        .tile_data      (tile_data),
        .last_of_item   (last_of_item),
        .image_done     (image_done),
        .outstanding    (outstanding),
        .walk_done      (walk_done),
        .mismatch_count (mismatch_count)
    );

    task automatic send_word(input kind_t kind, input logic [WORD_W-1:0] w);
        while (!calm && $urandom_range(0, 99) < 11)
        begin
            word_valid <= 1'b0;
            @(posedge clk);
        end
        word_valid <= 1'b1;
        cmd        <= kind;
        word       <= w;
        do
            @(posedge clk);
        while (word_stall);
    endtask

    task automatic send_run(input logic [WORD_W-1:0] value, input logic [WORD_W-1:0] count);
        send_word(KIND_DATA, '0);
        send_word(KIND_DATA, value);
        send_word(KIND_DATA, count);
    endtask

    task automatic drain();
        word_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        // words with no tile write may still sit in the block's queue
        repeat (12) @(posedge clk);
    endtask

    task automatic set_regs(input logic [BASE_W-1:0] base, input logic [ROWS_W-1:0] rows,
                            input logic [PAGE_W-1:0] pages, input bit spare);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DST_BASE;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_index <= CFG_ROWS_PER_PAGE;
        cfg_wdata <= {16'($urandom), rows};
        @(posedge clk);
        cfg_index <= CFG_PAGE_COUNT;
        cfg_wdata <= {21'($urandom), pages};
        @(posedge clk);
        if (spare)
        begin
            cfg_index <= CFG_SPARE;
            cfg_wdata <= 24'($urandom);
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] run_tile();
        if ($urandom_range(0, 9) == 0)
            return '0;
        return WORD_W'($urandom);
    endfunction

    function automatic logic [WORD_W-1:0] run_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return WORD_W'($urandom_range(0, 7));
        if (r < 7)
            return WORD_W'($urandom_range(8, 70));
        if (r < 9)
            return WORD_W'(ROW_COLS - 1);
        return WORD_W'($urandom);
    endfunction

    task automatic run_phase(input int k);
        int sent;
        int pick;
        sent = 0;
        case (k)
            0:       set_regs(24'h000000, 8'd1, 3'd2, 1'b0);
            1:       set_regs(24'hFFFFFF, 8'd255, 3'd4, 1'b0);
            2:       set_regs(24'($urandom), 8'd2, 3'd0, 1'b1);
            3:       set_regs(24'($urandom), 8'd0, 3'd7, 1'b0);
            default: set_regs(24'($urandom), 8'($urandom_range(0, 3)),
                              3'($urandom_range(1, 4)), 1'b0);
        endcase
        // some phases keep the walk going under the new settings
        if (k != 5 && k != 7)
            send_word(KIND_START, WORD_W'($urandom));
        while (sent < PHASE_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (walk_done && pick < 80)
            begin
                send_word(KIND_START, WORD_W'($urandom));
                sent++;
            end
            else if (pick < 45)
            begin
                send_word(KIND_DATA, WORD_W'($urandom_range(1, 65535)));
                sent++;
            end
            else if (pick < 88)
            begin
                send_run(run_tile(), run_count());
                sent += 3;
            end
            else if (pick < 94)
            begin
                // run cut short by a start
                send_word(KIND_DATA, '0);
                if ($urandom_range(0, 1) == 1)
                    send_word(KIND_DATA, WORD_W'($urandom));
                send_word(KIND_START, WORD_W'($urandom));
                sent += 2;
            end
            else
            begin
                send_word(kind_t'($urandom_range(0, 1)), WORD_W'($urandom));
                sent++;
            end
        end
        drain();
    endtask

    initial
    begin : tile_sink
        bit squeezed;
        squeezed = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze_on && !squeezed)
            begin
                squeezed = 1'b1;
                tile_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            tile_stall <= !calm && ($urandom_range(0, 99) < 11);
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, walk ready without a start
        send_word(KIND_DATA, 16'hFFFF);
        send_word(KIND_DATA, 16'h0001);
        send_run(16'h0000, 16'h0000);
        send_word(KIND_START, 16'h5A5A);
        send_run(16'hABCD, 16'hFFFF);
        send_run(16'h1234, 16'h003E);
        send_word(KIND_DATA, 16'h8000);
        drain();

        // one-row image near the top of the address space
        set_regs(24'hFFFFC0, 8'd0, 3'd1, 1'b1);
        send_word(KIND_START, 16'h0000);
        send_run(16'h7777, 16'h0040);
        send_word(KIND_DATA, 16'h4321);
        send_word(KIND_START, 16'hFFFF);
        send_word(KIND_DATA, 16'h0000);
        send_word(KIND_DATA, 16'h2222);
        send_word(KIND_START, 16'h0000);
        send_word(KIND_DATA, 16'h0F0F);
        drain();

        for (int k = 0; k < PHASES; k++)
        begin
            if (k == 3)
                squeeze_on <= 1'b1;
            if (k == 6)
                calm <= 1'b1;
            else if (k == 7)
                calm <= 1'b0;
            run_phase(k);
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
